// ===== design/drd_pkg.sv =====
// ----------------------------------------------------------------------------
// drd_pkg
// Shared types and constants of the detection row decode unit: register
// indexes and reset values, the queued row record and the result record.
// ----------------------------------------------------------------------------
package drd_pkg;

   // Row layout: four box values, then objectness, then the class scores.
   localparam int BOX_VALUES = 4;
   localparam int HEAD_LEN   = 5;

   // Reciprocal scale is unsigned Q8.16; it is multiplied in two halves.
   localparam int SCALE_W     = 24;
   localparam int SCALE_SPLIT = 12;
   localparam int SCALE_FRAC  = 16;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_ADDR_W-1:0] CSR_CLASS_COUNT     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCORE_THRESHOLD = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAD_LEFT        = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAD_TOP         = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_INV_SCALE       = 3'd4;

   localparam logic [7:0]         RST_CLASS_COUNT     = 8'd80;
   localparam logic [16:0]        RST_SCORE_THRESHOLD = 17'd16384;
   localparam logic [11:0]        RST_PAD             = 12'd0;
   localparam logic [SCALE_W-1:0] RST_INV_SCALE       = 24'd65536;

   // Queue between the row front end and the box arithmetic.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // One accepted row, as handed from the front end to the back end.
   typedef struct packed {
      logic signed [31:0] obj;
      logic [6:0]         cls;
      logic signed [31:0] h;
      logic signed [31:0] w;
      logic signed [31:0] y;
      logic signed [31:0] x;
   } box_rec_type;

   // Geometry registers used by the back end.
   typedef struct packed {
      logic [11:0]        pad_left;
      logic [11:0]        pad_top;
      logic [SCALE_W-1:0] inv_scale;
   } geom_cfg_type;

   // One decoded detection, in the bit order of the result beat.
   typedef struct packed {
      logic signed [31:0] objectness;
      logic [6:0]         class_index;
      logic signed [15:0] box_height;
      logic signed [15:0] box_width;
      logic signed [15:0] box_top;
      logic signed [15:0] box_left;
   } det_rec_type;

endpackage

// ===== design/detection_row_decode_unit.sv =====
// ----------------------------------------------------------------------------
// detection_row_decode_unit
// Decodes detector output rows streamed one Q16.16 value per beat into
// thresholded boxes in source pixels.
// ----------------------------------------------------------------------------
// The unit takes one value per clock: each row is center x, center y, width,
// height, objectness and then the configured number of class scores. The
// front end never stalls inside a row; it holds the last beat of a row only
// when the four-entry row queue is full, which happens only when the result
// side has been stalled. A passing row is written into the row queue when
// its last beat is taken, then runs through the numerator, partial-product
// and sum stages to the output register, which holds a finished result while
// new rows keep coming in. Rows of the minimum length (six beats) can be
// decoded at full rate indefinitely while results are taken. The user must
// write the configuration registers only while idle; the unit does not check.
// ----------------------------------------------------------------------------
module detection_row_decode_unit import drd_pkg::*; #(
   parameter int CLASS_LIMIT = 128,
   parameter int FRAC_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // [31:0] value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [15:0] box_left, [31:16] box_top, [47:32] box_width, [63:48] box_height,
   // [70:64] class_index, [102:71] objectness, [103] zero
   output logic [103:0]          rsp_tdata,
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [7:0]         class_count_ff;
   logic [16:0]        score_threshold_ff;
   logic [11:0]        pad_left_ff, pad_top_ff;
   logic [SCALE_W-1:0] inv_scale_ff;

   geom_cfg_type geom;
   box_rec_type  push_data, pop_data;
   det_rec_type  rsp_rec;
   logic         q_push, q_pop, q_full, q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         class_count_ff     <= RST_CLASS_COUNT;
         score_threshold_ff <= RST_SCORE_THRESHOLD;
         pad_left_ff        <= RST_PAD;
         pad_top_ff         <= RST_PAD;
         inv_scale_ff       <= RST_INV_SCALE;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_CLASS_COUNT:     class_count_ff     <= csr_wdata[7:0];
            CSR_SCORE_THRESHOLD: score_threshold_ff <= csr_wdata[16:0];
            CSR_PAD_LEFT:        pad_left_ff        <= csr_wdata[11:0];
            CSR_PAD_TOP:         pad_top_ff         <= csr_wdata[11:0];
            CSR_INV_SCALE:       inv_scale_ff       <= csr_wdata[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign geom.pad_left  = pad_left_ff;
   assign geom.pad_top   = pad_top_ff;
   assign geom.inv_scale = inv_scale_ff;

   drd_front #(
      .CLASS_LIMIT (CLASS_LIMIT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .class_count     (class_count_ff),
      .score_threshold (score_threshold_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_push_data     (push_data)
   );

   drd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .full      (q_full),
      .valid     (q_valid),
      .pop_data  (pop_data)
   );

   drd_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .geom       (geom),
      .q_valid    (q_valid),
      .q_data     (pop_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_rec)
   );

   assign rsp_tdata = {1'b0, rsp_rec};

endmodule

// ===== design/drd_front.sv =====
// ----------------------------------------------------------------------------
// drd_front
// Row front end: counts the position in the row, keeps the box values, the
// objectness and the running best class, and queues rows that pass the
// score threshold.
// ----------------------------------------------------------------------------
module drd_front import drd_pkg::*; #(
   parameter int CLASS_LIMIT = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,
   input  logic [7:0]   class_count,
   input  logic [16:0]  score_threshold,
   input  logic         q_full,
   output logic         q_push,
   output box_rec_type  q_push_data
);

   localparam int POS_W = $clog2(CLASS_LIMIT + HEAD_LEN);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   best_cls_ff, best_cls_in;
   logic signed [31:0] best_ff, best_in;
   logic signed [31:0] obj_ff;
   logic signed [31:0] box_ff [BOX_VALUES];

   logic [7:0]         n_cls;
   logic [POS_W-1:0]   last_pos;
   logic [POS_W-1:0]   cls_pos;
   logic [POS_W+6:0]   cls_wide;
   logic signed [31:0] v;
   logic signed [32:0] thr_s;
   logic               at_last, accept, in_box, is_obj, in_scores, is_first;
   logic               take_best, pass;

   // Class count of zero acts as one; counts above the maximum are clamped.
   always_comb begin
      n_cls = (class_count == 8'd0) ? 8'd1 : class_count;
      if (n_cls > 8'(CLASS_LIMIT)) begin
         n_cls = 8'(CLASS_LIMIT);
      end
      last_pos = POS_W'(n_cls) + POS_W'(HEAD_LEN - 1);
   end

   assign v          = req_tdata;
   assign at_last    = (pos_ff >= last_pos);
   // Only the row-ending beat needs room in the queue.
   assign req_tready = !(at_last && q_full);
   assign accept     = req_tvalid && req_tready;

   assign in_box    = (pos_ff < POS_W'(BOX_VALUES));
   assign is_obj    = (pos_ff == POS_W'(BOX_VALUES));
   assign in_scores = (pos_ff >= POS_W'(HEAD_LEN));
   assign is_first  = (pos_ff == POS_W'(HEAD_LEN));
   assign cls_pos   = pos_ff - POS_W'(HEAD_LEN);

   assign take_best   = in_scores && (is_first || (v > best_ff));
   assign best_in     = take_best ? v : best_ff;
   assign best_cls_in = take_best ? cls_pos : best_cls_ff;
   assign pos_in      = at_last ? '0 : pos_ff + POS_W'(1);

   assign thr_s = signed'({16'd0, score_threshold});
   assign pass  = (signed'({obj_ff[31], obj_ff}) >= thr_s) &&
                  (signed'({best_in[31], best_in}) > thr_s);

   assign cls_wide = {7'd0, best_cls_in};

   assign q_push           = accept && at_last && pass;
   assign q_push_data.x    = box_ff[0];
   assign q_push_data.y    = box_ff[1];
   assign q_push_data.w    = box_ff[2];
   assign q_push_data.h    = box_ff[3];
   assign q_push_data.obj  = obj_ff;
   assign q_push_data.cls  = cls_wide[6:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         best_cls_ff <= '0;
      end else if (accept) begin
         pos_ff      <= pos_in;
         best_cls_ff <= best_cls_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (in_box) begin
            box_ff[pos_ff[1:0]] <= v;
         end
         if (is_obj) begin
            obj_ff <= v;
         end
         best_ff <= best_in;
      end
   end

endmodule

// ===== design/drd_queue.sv =====
// ----------------------------------------------------------------------------
// drd_queue
// Short first-in first-out queue of accepted rows between the front end
// and the box arithmetic.
// ----------------------------------------------------------------------------
module drd_queue import drd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  box_rec_type push_data,
   input  logic        pop,
   output logic        full,
   output logic        valid,
   output box_rec_type pop_data
);

   box_rec_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full     = (cnt_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign valid    = (cnt_ff != '0);
   assign pop_data = mem_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) begin
            wr_ff <= wr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ff <= rd_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== design/drd_back.sv =====
// ----------------------------------------------------------------------------
// drd_back
// Box arithmetic: removes padding, applies the reciprocal scale, truncates
// toward zero and saturates to 16 bits. Four lanes (left, top, width,
// height) run through numerator, partial product, sum and output stages.
// ----------------------------------------------------------------------------
module drd_back import drd_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  geom_cfg_type geom,
   input  logic         q_valid,
   input  box_rec_type  q_data,
   output logic         q_pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output det_rec_type  rsp_data
);

   localparam int NUM_W  = ((FRAC_BITS + 14 > 34) ? FRAC_BITS + 14 : 34) + 1;
   localparam int MUL_W  = NUM_W + SCALE_SPLIT + 1;
   localparam int PRD_W  = NUM_W + SCALE_W + 1;
   localparam int PAD_SH = FRAC_BITS + 1;

   logic adv;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;

   logic signed [NUM_W-1:0] x_e, y_e, w_e, h_e, padl_e, padt_e;
   logic signed [NUM_W-1:0] num [BOX_VALUES];
   logic signed [NUM_W-1:0] s1_num_ff [BOX_VALUES];
   logic signed [MUL_W-1:0] s2_lo_ff [BOX_VALUES];
   logic signed [MUL_W-1:0] s2_hi_ff [BOX_VALUES];
   logic signed [PRD_W-1:0] s3_prd_ff [BOX_VALUES];
   logic signed [15:0]      sat [BOX_VALUES];

   logic [6:0]         s1_cls_ff, s2_cls_ff, s3_cls_ff;
   logic signed [31:0] s1_obj_ff, s2_obj_ff, s3_obj_ff;
   det_rec_type        rsp_ff;

   logic signed [SCALE_SPLIT:0] inv_lo, inv_hi;

   // The whole pipe moves whenever the output register can take a beat.
   assign adv   = !rsp_valid_ff || rsp_tready;
   assign q_pop = adv && q_valid;

   assign inv_lo = signed'({1'b0, geom.inv_scale[SCALE_SPLIT-1:0]});
   assign inv_hi = signed'({1'b0, geom.inv_scale[SCALE_W-1:SCALE_SPLIT]});

   // Edges are 2*center - size - 2*pad in half steps, so the edge lanes
   // shift right by one more bit than the extent lanes.
   always_comb begin
      x_e    = NUM_W'(q_data.x);
      y_e    = NUM_W'(q_data.y);
      w_e    = NUM_W'(q_data.w);
      h_e    = NUM_W'(q_data.h);
      padl_e = signed'(NUM_W'(geom.pad_left)) <<< PAD_SH;
      padt_e = signed'(NUM_W'(geom.pad_top)) <<< PAD_SH;
      num[0] = (x_e <<< 1) - w_e - padl_e;
      num[1] = (y_e <<< 1) - h_e - padt_e;
      num[2] = w_e;
      num[3] = h_e;
   end

   for (genvar l = 0; l < BOX_VALUES; l++) begin : g_lane
      localparam int SH = (l < 2) ? FRAC_BITS + SCALE_FRAC + 1 : FRAC_BITS + SCALE_FRAC;

      logic             neg;
      logic [PRD_W-1:0] mag;

      assign neg = (s3_prd_ff[l] < 0);
      assign mag = neg ? (unsigned'(-s3_prd_ff[l]) >> SH) : (unsigned'(s3_prd_ff[l]) >> SH);
      assign sat[l] = neg ?
         ((mag > PRD_W'(32768)) ? 16'sh8000 : signed'(16'd0 - mag[15:0])) :
         ((mag > PRD_W'(32767)) ? 16'sh7FFF : signed'(mag[15:0]));

      always_ff @(posedge clock) begin
         if (adv) begin
            s1_num_ff[l] <= num[l];
            s2_lo_ff[l]  <= s1_num_ff[l] * inv_lo;
            s2_hi_ff[l]  <= s1_num_ff[l] * inv_hi;
            s3_prd_ff[l] <= PRD_W'(s2_lo_ff[l]) + (PRD_W'(s2_hi_ff[l]) <<< SCALE_SPLIT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= q_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cls_ff              <= q_data.cls;
         s1_obj_ff              <= q_data.obj;
         s2_cls_ff              <= s1_cls_ff;
         s2_obj_ff              <= s1_obj_ff;
         s3_cls_ff              <= s2_cls_ff;
         s3_obj_ff              <= s2_obj_ff;
         rsp_ff.box_left        <= sat[0];
         rsp_ff.box_top         <= sat[1];
         rsp_ff.box_width       <= sat[2];
         rsp_ff.box_height      <= sat[3];
         rsp_ff.class_index     <= s3_cls_ff;
         rsp_ff.objectness      <= s3_obj_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== design/drd_checker.sv =====
// ----------------------------------------------------------------------------
// drd_checker
// Port-level checks of the detection row decode unit, bound to its top level.
// ----------------------------------------------------------------------------
module drd_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata
);

   // Reset empties the result register.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid right after reset");

   // Reset rewinds the row and empties the queue, so the input is open.
   a_ready_after_reset: assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready right after reset");

   // A stalled result beat keeps its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed or dropped");

   // A row takes at least six beats, so no result can show up soon after reset.
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3) &&
                            !$past(reset, 4) && !$past(reset, 5) && !$past(reset, 6))
      else $error("result beat too soon after reset");

   // The padding bit above the objectness field is always zero.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[103])
      else $error("padding bit of result beat set");

endmodule

bind detection_row_decode_unit drd_checker u_drd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
